// ===== rtl/nns_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler package
// Beat types, configuration register indexes and shared helpers for the
// RGB565 nearest-neighbor frame scaler.
// ----------------------------------------------------------------------------
package nns_pkg;

  // Every dimension register is 10 bits wide.
  localparam int unsigned DIM_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 4;

  // The quotient of a scaled coordinate fits in DIM_W bits, so the divider
  // needs one step per quotient bit.
  localparam int unsigned DIV_STEPS = DIM_W;

  localparam logic [DIM_W-1:0] DIM_RESET = 10'd240;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] pixel_565;
    logic        last_pixel;
  } out_beat_t;

  typedef struct packed {
    logic wr_pix;    // store the accepted source pixel
    logic start;     // latch the coordinates of a destination request
    logic mul;       // scale coordinates and load the dividers
    logic div_step;  // one restoring division step on both lanes
    logic addr;      // form the frame store read address
    logic read;      // read the frame store
    logic load_out;  // move the packed pixel into the output register
  } nns_cmd_t;

  typedef struct packed {
    logic div_last;  // the current division step is the final one
  } nns_status_t;

  function automatic logic [15:0] pack_565(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

// ===== rtl/nns_ctrl.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler controller
// Sequences a destination request through scaling, division, address
// generation and the frame store read, and owns the output valid flag.
// ----------------------------------------------------------------------------
module nns_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_kind_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  nns_pkg::nns_status_t status_i,
  output nns_pkg::nns_cmd_t   cmd_o
);
  import nns_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADDR,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_pix   = accept && (in_kind_i == KIND_LOAD);
    cmd_o.start    = accept && (in_kind_i == KIND_REQUEST);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.addr     = (state_q == ST_ADDR);
    cmd_o.read     = (state_q == ST_READ);
    // The finished pixel waits here until the output register is free.
    cmd_o.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_DONE;
      ST_DONE: begin
        if (cmd_o.load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/nns_datapath.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler datapath
// Dimension registers, raster counters, frame store, two-lane restoring
// divider and the RGB565 output register.
// ----------------------------------------------------------------------------
module nns_datapath #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nns_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [nns_pkg::DIM_W-1:0]           cfg_wdata_i,
  input  nns_pkg::in_beat_t                   in_data_i,
  input  nns_pkg::nns_cmd_t                   cmd_i,
  output nns_pkg::nns_status_t                status_o,
  output nns_pkg::out_beat_t                  out_data_o
);
  import nns_pkg::*;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SIZE_W = $clog2(DEPTH + 1);
  localparam int unsigned PROD_W = 2 * DIM_W;

  localparam logic [DIM_W-1:0] RST_SW =
    (32'(DIM_RESET) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_RESET;
  localparam logic [DIM_W-1:0] RST_SH =
    (32'(DIM_RESET) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_RESET;
  localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(RST_SW) * SIZE_W'(RST_SH);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Dimension registers hold the clamped values.
  logic [DIM_W-1:0]  sw_q, sh_q, dw_q, dh_q;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [DIM_W-1:0]  wr_clamp_w, wr_clamp_h;
  logic [DIM_W-1:0]  size_a, size_b;
  logic [PROD_W-1:0] size_prod;

  assign wr_clamp_w = clamp_dim(cfg_wdata_i, MAX_WIDTH);
  assign wr_clamp_h = clamp_dim(cfg_wdata_i, MAX_HEIGHT);

  // The source size follows every write to a source dimension.
  assign size_a    = (cfg_idx_i == CFG_SRC_WIDTH)  ? wr_clamp_w : sw_q;
  assign size_b    = (cfg_idx_i == CFG_SRC_HEIGHT) ? wr_clamp_h : sh_q;
  assign size_prod = size_a * size_b;
  assign size_d    = SIZE_W'(size_prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= RST_SW;
      sh_q   <= RST_SH;
      dw_q   <= RST_SW;
      dh_q   <= RST_SH;
      size_q <= RST_SIZE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_WIDTH: begin
          sw_q   <= wr_clamp_w;
          size_q <= size_d;
        end
        CFG_SRC_HEIGHT: begin
          sh_q   <= wr_clamp_h;
          size_q <= size_d;
        end
        CFG_DST_WIDTH:  dw_q <= wr_clamp_w;
        CFG_DST_HEIGHT: dh_q <= wr_clamp_h;
        default: ;
      endcase
    end
  end

  // Source write address.
  logic [ADDR_W-1:0] wa_q, wa_d, wa_eff;
  logic [SIZE_W-1:0] wa_inc;

  assign wa_eff = (SIZE_W'(wa_q) < size_q) ? wa_q : '0;
  assign wa_inc = SIZE_W'(wa_eff) + SIZE_W'(1);
  assign wa_d   = (wa_inc >= size_q) ? '0 : ADDR_W'(wa_inc);

  // Destination raster counters.
  logic [DIM_W-1:0] col_q, row_q, col_d, row_d, x_eff, y_eff;
  logic [DIM_W:0]   x_inc, y_inc;
  logic             last_d;

  assign x_eff  = (col_q < dw_q) ? col_q : '0;
  assign y_eff  = (row_q < dh_q) ? row_q : '0;
  assign x_inc  = {1'b0, x_eff} + (DIM_W + 1)'(1);
  assign y_inc  = {1'b0, y_eff} + (DIM_W + 1)'(1);
  assign last_d = (x_inc == {1'b0, dw_q}) && (y_inc == {1'b0, dh_q});

  always_comb begin
    if (x_inc >= {1'b0, dw_q}) begin
      col_d = '0;
      row_d = (y_inc >= {1'b0, dh_q}) ? '0 : DIM_W'(y_inc);
    end else begin
      col_d = DIM_W'(x_inc);
      row_d = y_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q  <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      if (cmd_i.wr_pix) begin
        wa_q <= wa_d;
      end
      if (cmd_i.start) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Request coordinates, scaling products and the two division lanes.
  logic [DIM_W-1:0]  x_q, y_q;
  logic              last_q;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [DIM_W-1:0]  rem_x_q, rem_y_q, quo_x_q, quo_y_q;
  logic [DIM_W:0]    trial_x, trial_y;
  logic              ge_x, ge_y;
  logic [CNT_W-1:0]  step_q;

  assign prod_x = x_q * sw_q;
  assign prod_y = y_q * sh_q;

  // The upper half of each product is already below the divisor, so only
  // the quotient bits remain to be resolved.
  assign trial_x = {rem_x_q, quo_x_q[DIM_W-1]};
  assign trial_y = {rem_y_q, quo_y_q[DIM_W-1]};
  assign ge_x    = (trial_x >= {1'b0, dw_q});
  assign ge_y    = (trial_y >= {1'b0, dh_q});

  assign status_o.div_last = (step_q == CNT_W'(DIV_STEPS - 1));

  logic [PROD_W-1:0] lin_mul;
  logic [PROD_W:0]   lin_addr;
  logic [ADDR_W-1:0] rd_addr_q;

  assign lin_mul  = quo_y_q * sw_q;
  assign lin_addr = (PROD_W + 1)'(lin_mul) + (PROD_W + 1)'(quo_x_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= x_eff;
      y_q    <= y_eff;
      last_q <= last_d;
    end
    if (cmd_i.mul) begin
      rem_x_q <= prod_x[PROD_W-1:DIM_W];
      quo_x_q <= prod_x[DIM_W-1:0];
      rem_y_q <= prod_y[PROD_W-1:DIM_W];
      quo_y_q <= prod_y[DIM_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_x_q <= ge_x ? DIM_W'(trial_x - {1'b0, dw_q}) : DIM_W'(trial_x);
      quo_x_q <= {quo_x_q[DIM_W-2:0], ge_x};
      rem_y_q <= ge_y ? DIM_W'(trial_y - {1'b0, dh_q}) : DIM_W'(trial_y);
      quo_y_q <= {quo_y_q[DIM_W-2:0], ge_y};
    end
    if (cmd_i.addr) begin
      rd_addr_q <= ADDR_W'(lin_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.mul) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + CNT_W'(1);
    end
  end

  // Frame store: one write port and one registered read port.
  logic [23:0] store_q [DEPTH];
  logic [23:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_pix) begin
      store_q[wa_eff] <= {in_data_i.red, in_data_i.green, in_data_i.blue};
    end
    if (cmd_i.read) begin
      rd_data_q <= store_q[rd_addr_q];
    end
  end

  out_beat_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.pixel_565  <= pack_565(rd_data_q);
      out_q.last_pixel <= last_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/nearest_neighbor_scaler_rgb565_top.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor RGB565 frame scaler
// Loads RGB888 source pixels into a frame store and streams scaled
// destination pixels packed as RGB565.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  nns_pkg::in_beat_t
//   out      output     out_valid_o/out_ready_i nns_pkg::out_beat_t
//   cfg      input      cfg_we_i (no wait)     cfg_idx_i, cfg_wdata_i
//
// A load beat is stored when it is accepted. A request beat latches the raster
// position, scales both coordinates, runs the shared one-bit-per-cycle division
// of both lanes, forms the read address and reads the frame store, then loads
// the output register.
// The output register lets the next beat be accepted while a pixel waits.
// A stalled output holds the controller before the load step of the next request.
// Reset clears counters and control; the frame store is not cleared.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_rgb565_top #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  nns_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output nns_pkg::out_beat_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [nns_pkg::DIM_W-1:0]     cfg_wdata_i
);
  import nns_pkg::*;

  nns_cmd_t    cmd;
  nns_status_t status;

  nns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nns_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/nns_checker.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor scaler port checker
// Watches the top level ports for ordering between accepted beats and
// delivered pixels.
// ----------------------------------------------------------------------------
module nns_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input nns_pkg::in_beat_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input nns_pkg::out_beat_t            out_data_o
);
  import nns_pkg::*;

  logic acc_load, acc_req;

  assign acc_load = in_valid_i && in_ready_o && (in_data_i.kind == KIND_LOAD);
  assign acc_req  = in_valid_i && in_ready_o && (in_data_i.kind == KIND_REQUEST);

  // A waiting pixel holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // A request closes the input right after it is accepted.
  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_req |=> !in_ready_o)
    else $error("input accepted right after a pixel request");

  // A new pixel only appears at the end of a request, when input is closed.
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("pixel appeared while the block was idle");

  // Loading a source pixel never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_load |=> !$rose(out_valid_o))
    else $error("pixel produced by a load beat");

endmodule

bind nearest_neighbor_scaler_rgb565_top nns_checker u_nns_checker (.*);

// ===== tb/nearest_neighbor_scaler_rgb565_top_tb.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbor RGB565 scaler testbench
// Loads source frames and requests scaled destination pixels under several
// frame geometries, including degenerate and clamped sizes and changes of
// size in the middle of a frame. Every output beat is checked against typed-in
// values or against a behavioral scaler kept inside the bench.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaler_rgb565_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nns_pkg::*;

  localparam int unsigned MAX_DIM      = 512;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned FILL_CAP     = 32;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_beat_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_beat_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_SRC_WIDTH;
  logic [DIM_W-1:0]     cfg_wdata_i = '0;

  // Shadow of the scaler: registers, counters and the source frame.
  logic [DIM_W-1:0] reg_src_w = DIM_RESET;
  logic [DIM_W-1:0] reg_src_h = DIM_RESET;
  logic [DIM_W-1:0] reg_dst_w = DIM_RESET;
  logic [DIM_W-1:0] reg_dst_h = DIM_RESET;
  int unsigned      load_addr = 0;
  int unsigned      dst_col   = 0;
  int unsigned      dst_row   = 0;
  logic [23:0]      source_frame [int unsigned];

  out_beat_t   pixel_queue [$];
  out_beat_t   seen_pixel;
  dir_row_t    directed_rows [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  nearest_neighbor_scaler_rgb565_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic int unsigned sample_addr();
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned x;
    int unsigned y;
    sw = eff_dim(reg_src_w);
    sh = eff_dim(reg_src_h);
    dw = eff_dim(reg_dst_w);
    dh = eff_dim(reg_dst_h);
    x  = (dst_col < dw) ? dst_col : 0;
    y  = (dst_row < dh) ? dst_row : 0;
    return (y * sh / dh) * sw + (x * sw / dw);
  endfunction

  // Applies one accepted beat to the shadow scaler and returns the pixel
  // that a request produces.
  task automatic advance_scaler(input in_beat_t b, output bit has_pixel,
                                output out_beat_t pix);
    int unsigned src_size;
    int unsigned dw;
    int unsigned dh;
    int unsigned x;
    int unsigned y;
    int unsigned a;
    logic [23:0] px;
    src_size  = eff_dim(reg_src_w) * eff_dim(reg_src_h);
    dw        = eff_dim(reg_dst_w);
    dh        = eff_dim(reg_dst_h);
    has_pixel = 1'b0;
    pix       = '0;
    if (b.kind == KIND_LOAD) begin
      a = (load_addr < src_size) ? load_addr : 0;
      source_frame[a] = {b.red, b.green, b.blue};
      a++;
      load_addr = (a >= src_size) ? 0 : a;
    end else begin
      a  = sample_addr();
      x  = (dst_col < dw) ? dst_col : 0;
      y  = (dst_row < dh) ? dst_row : 0;
      px = source_frame.exists(a) ? source_frame[a] : 24'h0;
      has_pixel       = 1'b1;
      pix.pixel_565   = {px[23:19], px[15:10], px[7:3]};
      pix.last_pixel  = (x + 1 == dw) && (y + 1 == dh);
      if (x + 1 >= dw) begin
        dst_col = 0;
        dst_row = (y + 1 >= dh) ? 0 : y + 1;
      end else begin
        dst_col = x + 1;
        dst_row = y;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Presents one beat from a falling edge and returns at the rising edge
  // that accepts it, so the next beat can follow without a gap.
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    bit        has_pixel;
    out_beat_t pix;
    advance_scaler(b, has_pixel, pix);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < 36);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (has_pixel) begin
      pixel_queue.push_back(typed ? want : pix);
    end
  endtask

  task automatic drain_scaler();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_SRC_WIDTH: begin
        reg_src_w = val;
      end
      CFG_SRC_HEIGHT: begin
        reg_src_h = val;
      end
      CFG_DST_WIDTH: begin
        reg_dst_w = val;
      end
      default: begin
        reg_dst_h = val;
      end
    endcase
  endtask

  function automatic in_beat_t random_beat(input logic kind);
    in_beat_t b;
    b.kind  = kind;
    b.red   = 8'($urandom);
    b.green = 8'($urandom);
    b.blue  = 8'($urandom);
    return b;
  endfunction

  // One geometry: program the registers while idle, load the start of the
  // source frame, then mostly requests with occasional loads that overwrite
  // the frame. Requests that would sample a pixel never loaded become loads.
  task automatic run_phase(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                           input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                           input int unsigned n_items);
    int unsigned fill;
    in_beat_t    b;
    drain_scaler();
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    fill = eff_dim(sw) * eff_dim(sh);
    if (fill > FILL_CAP) begin
      fill = FILL_CAP;
    end
    repeat (fill) send_beat(random_beat(KIND_LOAD), 1'b0, '0);
    repeat (n_items) begin
      b = random_beat(($urandom_range(0, 99) < 80) ? KIND_REQUEST : KIND_LOAD);
      if (b.kind == KIND_REQUEST && !source_frame.exists(sample_addr())) begin
        b.kind = KIND_LOAD;
      end
      send_beat(b, 1'b0, '0);
    end
  endtask

  function automatic dir_row_t mk_row(input logic kind, input logic [23:0] rgb,
                                      input bit typed, input logic [15:0] pix,
                                      input logic last);
    dir_row_t r;
    r.beat = {kind, rgb};
    r.typed = typed;
    r.want.pixel_565 = pix;
    r.want.last_pixel = last;
    return r;
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_queue.size() == 0) begin
        report_mismatch("output beat with no pixel pending");
      end else begin
        seen_pixel = pixel_queue.pop_front();
        if (out_data_o.pixel_565 !== seen_pixel.pixel_565) begin
          report_mismatch($sformatf("pixel_565 got %h want %h",
                                    out_data_o.pixel_565, seen_pixel.pixel_565));
        end
        if (out_data_o.last_pixel !== seen_pixel.last_pixel) begin
          report_mismatch($sformatf("last_pixel got %b want %b",
                                    out_data_o.last_pixel, seen_pixel.last_pixel));
        end
      end
    end
  end

  initial begin
    logic [DIM_W-1:0] rsw;
    logic [DIM_W-1:0] rsh;
    logic [DIM_W-1:0] rdw;
    logic [DIM_W-1:0] rdh;
    int unsigned      pick;

    // With the reset geometry of 240 by 240 the first row maps one to one
    // onto the source row, so the packed values can be typed in directly.
    directed_rows.push_back(mk_row(KIND_LOAD, 24'hFFFFFF, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'h000000, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'hFF0000, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'h00FF00, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'h0000FF, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'h070307, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'hF8FCF8, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'hAA55AA, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'h000000, 1'b1, 16'hFFFF, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'hFFFFFF, 1'b1, 16'h0000, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'h000000, 1'b1, 16'hF800, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'hFFFFFF, 1'b1, 16'h07E0, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'h000000, 1'b1, 16'h001F, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'hFFFFFF, 1'b1, 16'h0000, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'h000000, 1'b1, 16'hFFFF, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'hFFFFFF, 1'b1, 16'hAAB5, 1'b0));
    directed_rows.push_back(mk_row(KIND_LOAD, 24'h55AA55, 1'b0, '0, 1'b0));
    directed_rows.push_back(mk_row(KIND_REQUEST, 24'h123456, 1'b0, '0, 1'b0));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end

    // Fixed geometries: upscale, zero registers acting as one, clamped
    // extremes in each direction, downscale and a destination too large
    // to finish, which leaves the next phase to start mid-frame.
    run_phase(10'd4, 10'd3, 10'd7, 10'd5, 40);
    run_phase(10'd0, 10'd0, 10'd0, 10'd1, 30);
    run_phase(10'd1023, 10'd1, 10'd1023, 10'd1, 60);
    run_phase(10'd1, 10'd600, 10'd2, 10'd1023, 40);
    run_phase(10'd9, 10'd7, 10'd3, 10'd2, 40);
    run_phase(10'd5, 10'd5, 10'd1023, 10'd1023, 40);

    for (int p = 0; p < 6; p++) begin
      calm = (p == 2 || p == 3);
      rsw  = ($urandom_range(0, 99) < 10) ? 10'd0 : 10'($urandom_range(1, 12));
      rsh  = ($urandom_range(0, 99) < 10) ? 10'd0 : 10'($urandom_range(1, 12));
      pick = $urandom_range(0, 99);
      rdw  = (pick < 8) ? 10'd0 : (pick < 16) ? 10'($urandom_range(513, 1023)) :
             10'($urandom_range(1, 16));
      pick = $urandom_range(0, 99);
      rdh  = (pick < 8) ? 10'd0 : (pick < 16) ? 10'($urandom_range(513, 1023)) :
             10'($urandom_range(1, 16));
      run_phase(rsw, rsh, rdw, rdh, 36);
    end
    calm = 1'b0;

    drain_scaler();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
